// File: hw/rtl/lqt_pkg.sv
package lqt_pkg;

  localparam int SAMPLES_PER_VERDICT = 10;
  localparam int LIGHT_BITS          = 12;

  localparam int NUM_SENSORS = 4;
  localparam int IN_W        = 12;
  localparam int SUM_W       = 16;
  localparam int AVG_W       = LIGHT_BITS;
  localparam int MARGIN_W    = 12;
  localparam int ANG_W       = 8;
  localparam int CNT_W       = $clog2(SAMPLES_PER_VERDICT + 1);

  // floor(sum / N) as (sum * RECIP) >> DIV_SHIFT; the five spare bits keep it exact
  localparam int DIV_SHIFT = SUM_W + 5;
  localparam int RECIP     = ((2 ** DIV_SHIFT) + SAMPLES_PER_VERDICT - 1) / SAMPLES_PER_VERDICT;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam int IN_DATA_W  = NUM_SENSORS * IN_W;
  localparam int OUT_DATA_W = 24;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(30);
  localparam logic [ANG_W-1:0]    SERVO_HOME   = ANG_W'(45);
  localparam logic [ANG_W-1:0]    AIM_LOW      = ANG_W'(30);
  localparam logic [ANG_W-1:0]    AIM_HIGH     = ANG_W'(60);
  localparam logic [ANG_W-1:0]    AIM_WIDE     = ANG_W'(76);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    REG_NEUTRAL = 4'd0,
    REG_S1      = 4'd1,
    REG_S2      = 4'd2,
    REG_S3      = 4'd3,
    REG_S4      = 4'd4,
    REG_P12     = 4'd5,
    REG_P23     = 4'd6,
    REG_P34     = 4'd7,
    REG_P41     = 4'd8
  } region_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [ANG_W-1:0] angle_t;

  typedef struct packed {
    angle_t one;
    angle_t two;
  } aim_t;

  function automatic aim_t region_aim(input region_t r);
    aim_t a;
    unique case (r)
      REG_NEUTRAL: a = '{one: SERVO_HOME, two: SERVO_HOME};
      REG_S1:      a = '{one: AIM_LOW,    two: AIM_LOW};
      REG_S2:      a = '{one: AIM_HIGH,   two: AIM_HIGH};
      REG_S3:      a = '{one: AIM_HIGH,   two: AIM_LOW};
      REG_S4:      a = '{one: AIM_LOW,    two: AIM_HIGH};
      REG_P12:     a = '{one: AIM_HIGH,   two: AIM_HIGH};
      REG_P23:     a = '{one: AIM_HIGH,   two: SERVO_HOME};
      REG_P34:     a = '{one: AIM_LOW,    two: AIM_WIDE};
      REG_P41:     a = '{one: AIM_LOW,    two: SERVO_HOME};
      default:     a = '{one: SERVO_HOME, two: SERVO_HOME};
    endcase
    return a;
  endfunction

  function automatic angle_t step_toward(input angle_t pos, input angle_t aim);
    angle_t r;
    if (pos < aim) begin
      r = pos + ANG_W'(1);
    end else if (pos > aim) begin
      r = pos - ANG_W'(1);
    end else begin
      r = pos;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/light_quadrant_tracker_servo_ramp.sv
// Light quadrant tracker with servo ramp.
//
// Input stream (in_*): one transaction per item. in_tuser selects the kind:
// a light sample (four readings in in_tdata) or a servo step tick. Every
// SAMPLES_PER_VERDICT samples the window averages are classified into a
// dark-region code that sets new servo targets; each tick moves both servo
// angles one degree toward their targets.
// Output stream (out_*): exactly one result per input item, in order, with
// the region code and the angles as they stand after that item.
// cfg_*: writes the 12-bit light margin; always ready, write only when idle.
//
// Pipeline: an accepted item passes the input stage register, then the
// output register, before out_tvalid rises. One item per cycle sustained
// while the output is not stalled: the state update sits between the input
// stage register and the output register. When out_tready is low the output
// register holds, the input stage fills, and in_tready drops after that.
// Reset: window sums and count clear, region neutral, angles and targets
// at 45 degrees, margin 30, both stages empty.
module light_quadrant_tracker_servo_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lqt_pkg::MARGIN_W-1:0]      cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // light_one, light_two, light_three, light_four
  input  logic [lqt_pkg::IN_DATA_W-1:0]     in_tdata,
  // op
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // region_code, angle_one, angle_two, at_target, zero fill
  output logic [lqt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // verdict_ready
  output logic                              out_tuser
);
  import lqt_pkg::*;

  logic                      s1_vld_r;
  op_t                       s1_op_r;
  logic [IN_W-1:0]           s1_light_r [NUM_SENSORS];
  logic                      out_vld_r;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_user_r;

  logic [MARGIN_W-1:0]       margin_r;
  sum_t [3:0]                sums_r;
  sum_t [3:0]                sums_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  region_t                   region_r;
  region_t                   region_nxt;
  region_t                   region_v;
  angle_t                    ang1_r, ang2_r, ang1_nxt, ang2_nxt;
  aim_t                      tgt_r, tgt_nxt;
  logic                      adv;
  logic                      in_acc;
  logic                      win_end;
  logic                      at_tgt;

  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign win_end = (s1_op_r == OP_SAMPLE) && (cnt_r == CNT_W'(SAMPLES_PER_VERDICT - 1));

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sums_nxt[i] = sums_r[i] + SUM_W'(s1_light_r[i][LIGHT_BITS-1:0]);
    end
  end

  lqt_verdict u_verdict (
    .sums   (sums_nxt),
    .margin (margin_r),
    .region (region_v)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    region_nxt = region_r;
    tgt_nxt    = tgt_r;
    ang1_nxt   = ang1_r;
    ang2_nxt   = ang2_r;
    if (s1_op_r == OP_SAMPLE) begin
      if (win_end) begin
        cnt_nxt    = '0;
        region_nxt = region_v;
        tgt_nxt    = region_aim(region_v);
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      ang1_nxt = step_toward(ang1_r, tgt_r.one);
      ang2_nxt = step_toward(ang2_r, tgt_r.two);
    end
    at_tgt = (ang1_nxt == tgt_nxt.one) && (ang2_nxt == tgt_nxt.two);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      margin_r  <= MARGIN_RESET;
      sums_r    <= '0;
      cnt_r     <= '0;
      region_r  <= REG_NEUTRAL;
      ang1_r    <= SERVO_HOME;
      ang2_r    <= SERVO_HOME;
      tgt_r     <= '{one: SERVO_HOME, two: SERVO_HOME};
    end else begin
      if (cfg_valid && cfg_ready) begin
        margin_r <= cfg_data;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (adv) begin
        if (s1_op_r == OP_SAMPLE) begin
          sums_r <= win_end ? '0 : sums_nxt;
        end
        cnt_r    <= cnt_nxt;
        region_r <= region_nxt;
        tgt_r    <= tgt_nxt;
        ang1_r   <= ang1_nxt;
        ang2_r   <= ang2_nxt;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= op_t'(in_tuser);
      for (int i = 0; i < NUM_SENSORS; i++) begin
        s1_light_r[i] <= in_tdata[i*IN_W +: IN_W];
      end
    end
    if (adv) begin
      out_user_r <= win_end;
      out_data_r <= OUT_DATA_W'({at_tgt, ang2_nxt, ang1_nxt, region_nxt});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SAMPLES_PER_VERDICT - 1))
    else $error("sample count past window length");

  a_window_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && win_end) |=> (cnt_r == '0) && (sums_r == '0))
    else $error("window end did not clear sums and count");

  a_sample_holds_angles: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_SAMPLE) |=> $stable(ang1_r) && $stable(ang2_r))
    else $error("servo angle moved on a sample");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_TICK) |=>
      (ang1_r == $past(ang1_r) || ang1_r == $past(ang1_r) + ANG_W'(1) ||
       ang1_r == $past(ang1_r) - ANG_W'(1)) && $stable(tgt_r) && $stable(region_r))
    else $error("tick moved servo by more than one step or changed targets");

  a_stage_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input stalled with empty stage");

endmodule

// File: hw/rtl/lqt_verdict.sv
// Averages the four window sums and sorts them into a dark-region code.
module lqt_verdict (
  input  lqt_pkg::sum_t [3:0]                 sums,
  input  logic [lqt_pkg::MARGIN_W-1:0]        margin,
  output lqt_pkg::region_t                    region
);
  import lqt_pkg::*;

  logic [PROD_W-1:0] prod [NUM_SENSORS];
  logic [AVG_W-1:0]  avg  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0][NUM_SENSORS-1:0] dk;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      prod[i] = PROD_W'(sums[i]) * PROD_W'(RECIP);
      avg[i]  = prod[i][DIV_SHIFT +: AVG_W];
    end
  end

  // dk[x][y]: sensor x lies below sensor y by more than the margin, no wrap
  always_comb begin
    for (int x = 0; x < NUM_SENSORS; x++) begin
      for (int y = 0; y < NUM_SENSORS; y++) begin
        dk[x][y] = ({1'b0, avg[x]} + {1'b0, margin}) < {1'b0, avg[y]};
      end
    end
  end

  // singles first, then pairs; first hit wins
  always_comb begin
    priority if (dk[0][1] && dk[0][2] && dk[0][3]) begin
      region = REG_S1;
    end else if (dk[1][0] && dk[1][2] && dk[1][3]) begin
      region = REG_S2;
    end else if (dk[2][0] && dk[2][1] && dk[2][3]) begin
      region = REG_S3;
    end else if (dk[3][0] && dk[3][1] && dk[3][2]) begin
      region = REG_S4;
    end else if (dk[0][2] && dk[0][3] && dk[1][2] && dk[1][3]) begin
      region = REG_P12;
    end else if (dk[1][0] && dk[1][3] && dk[2][0] && dk[2][3]) begin
      region = REG_P23;
    end else if (dk[2][0] && dk[2][1] && dk[3][0] && dk[3][1]) begin
      region = REG_P34;
    end else if (dk[3][1] && dk[3][2] && dk[0][1] && dk[0][2]) begin
      region = REG_P41;
    end else begin
      region = REG_NEUTRAL;
    end
  end

endmodule
